FILE: rtl/bkf_pkg.sv
// Shared types for the bottom-k sketch filter.
// Used by the rank cells, the output stage and the top level; no dependencies.
package bkf_pkg;

  localparam int RANK_W   = 32;
  localparam int VERTEX_W = 31;
  localparam int DIST_W   = 32;
  localparam int CFG_W    = 7;

  // Reset value of the keep count register, before saturation to the row length.
  localparam logic [CFG_W-1:0] KEEP_COUNT_RESET = 7'd16;

  // What one cell shows its right-hand neighbor.
  typedef struct packed {
    logic              valid;  // cell holds a rank for the current item
    logic              gt;     // held rank is greater than the incoming rank
    logic [RANK_W-1:0] rank;
  } bkf_link_t;

  // What the top level drives into every cell.
  typedef struct packed {
    logic              fire;   // an item is accepted this cycle
    logic              start;  // the item opens a new sketch
    logic              keep;   // the item's rank goes into the row
    logic              grow;   // the row takes one more rank
    logic [RANK_W-1:0] rank;
  } bkf_bcast_t;

  // One result item.
  typedef struct packed {
    logic                keep;
    logic [VERTEX_W-1:0] vertex;
    logic [DIST_W-1:0]   distance;
  } bkf_result_t;

endpackage

FILE: rtl/bkf_cell.sv
// One slot of the sorted rank row of the bottom-k sketch filter.
// Depends on bkf_pkg for the link and broadcast structs.
module bkf_cell
  import bkf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bkf_bcast_t bcast,
  input  bkf_link_t  prev,
  output bkf_link_t  link
);

  logic              valid;
  logic [RANK_W-1:0] rank;
  logic              v_eff;
  logic              gt;
  logic              here;

  // A start item sees the row as empty.
  assign v_eff = valid & ~bcast.start;
  assign gt    = v_eff & (rank > bcast.rank);

  // The new rank lands here if this is the first held rank above it, or if
  // this is the first free slot and the row grows.
  assign here = v_eff ? gt : (bcast.grow & prev.valid);

  assign link.valid = v_eff;
  assign link.gt    = gt;
  assign link.rank  = rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bcast.fire) begin
      valid <= v_eff | (bcast.grow & prev.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.fire && bcast.keep) begin
      if (prev.gt) begin
        rank <= prev.rank;
      end else if (here) begin
        rank <= bcast.rank;
      end
    end
  end

endmodule

FILE: rtl/bkf_out_stage.sv
// Output register with a skid slot for the bottom-k sketch filter.
// Depends on bkf_pkg for the result struct.
module bkf_out_stage
  import bkf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  output logic        load_ready,
  input  bkf_result_t result_in,
  output logic        out_valid,
  input  logic        out_ready,
  output bkf_result_t result_out
);

  logic        skid_valid;
  bkf_result_t skid;

  // The skid slot only fills while the output register is stalled, so the
  // ready toward the row depends on a register alone.
  assign load_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        result_out <= skid;
      end else if (load) begin
        result_out <= result_in;
      end
    end else if (load) begin
      skid <= result_in;
    end
  end

endmodule

FILE: rtl/bottom_k_sketch_filter.sv
// Top level of the bottom-k sketch filter: a row of rank cells and an output stage.
// Depends on bkf_pkg, bkf_cell and bkf_out_stage.
//
// Use: entries of one vertex's all-distances sketch arrive on the input channel
// (in_valid/in_ready) ordered by distance, then vertex. An item with start_sketch
// set opens a new sketch and empties the rank row first. Each item yields exactly
// one result item on the output channel (out_valid/out_ready) that echoes the
// vertex and distance with a keep flag. The configuration channel
// (cfg_valid/cfg_ready, cfg_data) sets k, saturated to 1..MAX_KEEP; cfg_ready is
// always high and writes are meant for an idle block.
// The result is registered in the output stage. Throughput is one item per
// cycle while in_ready is high: the row of MAX_KEEP cells compares every held
// rank against the new one at once and shifts the larger ranks one cell to the
// right, all in the cycle of acceptance, so the next item sees the updated row.
// A two-entry output stage (register plus skid slot) holds results while the
// receiver stalls; in_ready drops only when both entries are full.
// Synchronous reset empties the row and the output stage and sets k to 16
// (or MAX_KEEP if that is smaller). There is no clearing pass: valid bits do it.
module bottom_k_sketch_filter
  import bkf_pkg::*;
#(
  parameter int MAX_KEEP = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                start_sketch,
  input  logic [VERTEX_W-1:0] entry_vertex,
  input  logic [DIST_W-1:0]   entry_distance,
  input  logic [RANK_W-1:0]   entry_rank,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                keep,
  output logic [VERTEX_W-1:0] out_vertex,
  output logic [DIST_W-1:0]   out_distance,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  // Wide enough for the raw register and for MAX_KEEP itself.
  localparam int KCW = ($clog2(MAX_KEEP + 1) > CFG_W) ? $clog2(MAX_KEEP + 1) : CFG_W;

  function automatic logic [KCW-1:0] sat_k(input logic [CFG_W-1:0] value);
    logic [KCW-1:0] k;
    k = KCW'(value);
    if (k == '0) begin
      k = KCW'(1);
    end else if (k > KCW'(MAX_KEEP)) begin
      k = KCW'(MAX_KEEP);
    end
    return k;
  endfunction

  logic [KCW-1:0] keff;
  logic           accept;
  logic           stage_ready;
  bkf_bcast_t     bcast;
  bkf_link_t      head;
  bkf_link_t      links [MAX_KEEP];
  logic [MAX_KEEP-1:0] gt_vec;
  logic [MAX_KEEP-1:0] at_limit;
  logic           full;
  logic           keep_item;
  bkf_result_t    result_in;
  bkf_result_t    result_out;

  // The effective k is saturated when written, so the row sees a legal value.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keff <= sat_k(KEEP_COUNT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      keff <= sat_k(cfg_data);
    end
  end

  assign in_ready = stage_ready;
  assign accept   = in_valid & in_ready;

  // The first cell's left neighbor is a held slot with no larger rank, so an
  // empty row grows into cell zero.
  assign head = '{valid: 1'b1, gt: 1'b0, rank: '0};

  generate
    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      if (i == 0) begin : g_first
        bkf_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .bcast (bcast),
          .prev  (head),
          .link  (links[i])
        );
      end else begin : g_rest
        bkf_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .bcast (bcast),
          .prev  (links[i-1]),
          .link  (links[i])
        );
      end
      assign gt_vec[i]   = links[i].gt;
      // The row is full when the cell at position k-1 holds a rank; a row that
      // holds more than k after k was lowered counts as full as well.
      assign at_limit[i] = links[i].valid & (keff <= KCW'(i + 1));
    end
  endgenerate

  assign full = |at_limit;

  // Because the row is sorted, some held rank exceeds the new one exactly when
  // the largest held rank does.
  assign keep_item = ~full | (|gt_vec);

  assign bcast.fire  = accept;
  assign bcast.start = start_sketch;
  assign bcast.keep  = keep_item;
  assign bcast.grow  = ~full;
  assign bcast.rank  = entry_rank;

  assign result_in.keep     = keep_item;
  assign result_in.vertex   = entry_vertex;
  assign result_in.distance = entry_distance;

  bkf_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_ready (stage_ready),
    .result_in  (result_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_out)
  );

  assign keep         = result_out.keep;
  assign out_vertex   = result_out.vertex;
  assign out_distance = result_out.distance;

endmodule

FILE: rtl/bkf_checker.sv
// Port-level checks for the bottom-k sketch filter, bound to the top level.
// Depends on bkf_pkg for field widths.
module bkf_checker
  import bkf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                start_sketch,
  input logic                out_valid,
  input logic                out_ready,
  input logic                keep,
  input logic [VERTEX_W-1:0] out_vertex,
  input logic [DIST_W-1:0]   out_distance
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // Items accepted whose results are not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(keep) && $stable(out_vertex)
                                && $stable(out_distance))
    else $error("result changed while stalled");

  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> pending == 2'd0)
    else $error("an accepted item has no result showing");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pending == 2'd2)
    else $error("input stalled with room in the output stage");

  a_start_kept: assert property (@(posedge clk) disable iff (rst)
    in_acc && start_sketch && (!out_valid || out_ready) |=> out_valid && keep)
    else $error("first entry of a sketch was dropped");

endmodule

bind bottom_k_sketch_filter bkf_checker u_bkf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .start_sketch   (start_sketch),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .keep           (keep),
  .out_vertex     (out_vertex),
  .out_distance   (out_distance)
);

FILE: test/tb.sv
// Self-checking testbench for the bottom-k sketch filter.
// Drives sketch entries and keep-count writes, predicts every result item
// and checks it. Depends on bkf_pkg and bottom_k_sketch_filter.
`timescale 1ns / 100ps

module tb;
  import bkf_pkg::*;

  localparam int MAX_KEEP    = 64;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Window of cycles in which neither side inserts random idle cycles.
  localparam int CALM_FROM   = 700;
  localparam int CALM_UNTIL  = 1100;

  typedef struct {
    logic                start;
    logic [VERTEX_W-1:0] vertex;
    logic [DIST_W-1:0]   distance;
    logic [RANK_W-1:0]   rank;
  } sketch_entry_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                start_sketch   = 1'b0;
  logic [VERTEX_W-1:0] entry_vertex   = '0;
  logic [DIST_W-1:0]   entry_distance = '0;
  logic [RANK_W-1:0]   entry_rank     = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic                keep;
  logic [VERTEX_W-1:0] out_vertex;
  logic [DIST_W-1:0]   out_distance;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data       = KEEP_COUNT_RESET;

  bottom_k_sketch_filter #(
    .MAX_KEEP(MAX_KEEP)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_sketch  (start_sketch),
    .entry_vertex  (entry_vertex),
    .entry_distance(entry_distance),
    .entry_rank    (entry_rank),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .keep          (keep),
    .out_vertex    (out_vertex),
    .out_distance  (out_distance),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Entries waiting to be driven, and result items waiting to be seen.
  sketch_entry_t pending_entries[$];
  bkf_result_t   expected_results[$];

  // Our own copy of the block's state: the keep-count register and the
  // ascending row of held ranks with its fill level.
  logic [CFG_W-1:0]  keep_reg = KEEP_COUNT_RESET;
  logic [RANK_W-1:0] held_store[MAX_KEEP];
  int unsigned       held_n = 0;

  // Cursors of the entry generator, so that a sketch can be continued later.
  logic [DIST_W-1:0]   dist_cursor   = '0;
  logic [VERTEX_W-1:0] vertex_cursor = '0;

  int unsigned failures        = 0;
  int unsigned entries_taken   = 0;
  int unsigned sketches_opened = 0;
  int unsigned kept_total      = 0;
  int unsigned settings_seen   = 1;
  int unsigned quiet_cycles    = 0;
  int unsigned cycle_count     = 0;
  logic        calm;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_UNTIL);

  initial begin
    forever #1 clk = ~clk;
  end

  // Bottom-k filter step. Returns the keep flag and updates the held row.
  // The effective k is the register saturated to 1..MAX_KEEP. A kept entry
  // grows the row while it is below k; otherwise it replaces only the single
  // largest rank, so after k is lowered the row does not shrink until a new sketch starts.
  // A rank equal to the largest held one is dropped once the row is full.
  function automatic bit filter_rank(logic start, logic [RANK_W-1:0] r);
    int unsigned k;
    int unsigned slot;
    k = (keep_reg == 0) ? 1 : (keep_reg > MAX_KEEP) ? MAX_KEEP : keep_reg;
    if (start) held_n = 0;
    if (held_n < k) begin
      slot = held_n;
      held_n++;
    end else if (held_store[held_n-1] > r) begin
      slot = held_n - 1;
    end else begin
      return 1'b0;
    end
    // Shift larger ranks one place up and drop the new rank into the gap.
    while (slot > 0 && held_store[slot-1] > r) begin
      held_store[slot] = held_store[slot-1];
      slot--;
    end
    held_store[slot] = r;
    return 1'b1;
  endfunction

  task automatic queue_entry(logic s, logic [VERTEX_W-1:0] v, logic [DIST_W-1:0] d,
                             logic [RANK_W-1:0] r);
    sketch_entry_t e;
    e.start    = s;
    e.vertex   = v;
    e.distance = d;
    e.rank     = r;
    pending_entries.push_back(e);
  endtask

  // One sketch of len entries. With open set, the first item starts a new
  // sketch; without it the entries extend whatever sketch the block holds.
  // Most sketches are ordered by distance, then vertex; a few are scrambled.
  // The rank style is chosen per sketch: wide random, a tiny pool that makes
  // ties common, or a mix of the extreme values.
  task automatic queue_sketch(int unsigned len, bit open);
    logic [RANK_W-1:0] r;
    int unsigned       rank_mode;
    bit                scrambled;
    rank_mode = $urandom_range(0, 3);
    scrambled = ($urandom_range(0, 9) == 0);
    for (int unsigned n = 0; n < len; n++) begin
      if (scrambled || (open && n == 0)) begin
        dist_cursor   = scrambled ? $urandom : $urandom_range(0, 32'hFFF0_0000);
        vertex_cursor = VERTEX_W'($urandom);
      end else if ($urandom_range(0, 2) == 0 || vertex_cursor > 31'h7FFF_0000) begin
        dist_cursor   = dist_cursor + $urandom_range(1, 1000);
        vertex_cursor = VERTEX_W'($urandom);
      end else begin
        vertex_cursor = VERTEX_W'(vertex_cursor + $urandom_range(1, 500));
      end
      case (rank_mode)
        0, 1: r = $urandom;
        2: r = $urandom_range(0, 15);
        default: begin
          case ($urandom_range(0, 2))
            0: r = '0;
            1: r = '1;
            default: r = $urandom;
          endcase
        end
      endcase
      queue_entry(open && n == 0, vertex_cursor, dist_cursor, r);
    end
  endtask

  // Exactly total entries: sketches of up to span entries, with
  // stray random entries mixed in between them.
  task automatic queue_items(int unsigned total, int unsigned span);
    int unsigned len;
    while (total > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_entry($urandom_range(0, 3) == 0, VERTEX_W'($urandom), $urandom, $urandom);
        total--;
      end else begin
        len = $urandom_range(1, span);
        if (len > total) len = total;
        queue_sketch(len, 1'b1);
        total -= len;
      end
    end
  endtask

  // Sampled at the falling edge, away from the edges where items move.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_entries.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic set_keep(logic [CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Input driver: presents the next pending item, holding it until accepted,
  // and inserts random idle cycles outside the calm window.
  always @(posedge clk) begin : entry_driver
    sketch_entry_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_entries.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        e = pending_entries.pop_front();
        in_valid       <= 1'b1;
        start_sketch   <= e.start;
        entry_vertex   <= e.vertex;
        entry_distance <= e.distance;
        entry_rank     <= e.rank;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls on its own random schedule.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // Monitor: tracks register writes, predicts each accepted item and checks
  // every accepted result against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    bkf_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        keep_reg = cfg_data;
        settings_seen++;
      end
      if (in_valid && in_ready) begin
        want.keep     = filter_rank(start_sketch, entry_rank);
        want.vertex   = entry_vertex;
        want.distance = entry_distance;
        expected_results.push_back(want);
        entries_taken++;
        if (start_sketch) sketches_opened++;
        if (want.keep) kept_total++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: keep %0b vertex %h distance %h",
                   $time, keep, out_vertex, out_distance);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (keep !== want.keep) begin
            $display("%0t: keep: expected %0b, actual %0b", $time, want.keep, keep);
            failures++;
          end
          if (out_vertex !== want.vertex) begin
            $display("%0t: out_vertex: expected %h, actual %h",
                     $time, want.vertex, out_vertex);
            failures++;
          end
          if (out_distance !== want.distance) begin
            $display("%0t: out_distance: expected %h, actual %h",
                     $time, want.distance, out_distance);
            failures++;
          end
        end
      end
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned k_pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset value of k (16). Fill the row with sixteen
    // ranks whose largest is all ones, offer that same rank again (a tie with
    // the largest, dropped), then zero (kept, evicts the top), then all ones
    // with the extreme vertex and distance (dropped). A new sketch must keep
    // its first entry, here with the extreme vertex and distance, and a final
    // entry goes back to distance zero unsorted.
    queue_entry(1'b1, '0, '0, '1);
    for (int i = 1; i <= 15; i++) queue_entry(1'b0, VERTEX_W'(i), '0, RANK_W'(i * 1000));
    queue_entry(1'b0, VERTEX_W'(100), DIST_W'(5), '1);
    queue_entry(1'b0, VERTEX_W'(101), DIST_W'(5), '0);
    queue_entry(1'b0, '1, '1, '1);
    queue_entry(1'b1, '1, '1, RANK_W'(15000));
    queue_entry(1'b0, '0, '0, '0);

    // Smallest k: a newly started sketch holds only one rank.
    set_keep(CFG_W'(1));
    queue_items(130, 10);

    // Largest k, ending in a long sketch that fills the whole row.
    set_keep(CFG_W'(MAX_KEEP));
    queue_items(200, 140);
    queue_sketch(100, 1'b1);

    // k lowered inside that sketch: the row stays above k and kept entries
    // evict only the single largest rank.
    set_keep(CFG_W'(4));
    queue_sketch(40, 1'b0);
    queue_items(80, 16);

    // Out-of-range register values saturate: zero acts as one, large values
    // act as the row length.
    set_keep(CFG_W'(0));
    queue_items(120, 8);
    set_keep(CFG_W'(127));
    queue_items(150, 150);
    set_keep(CFG_W'(65));
    queue_items(150, 150);
    set_keep(CFG_W'(2));
    queue_items(120, 10);

    // A few random settings, mostly small so that rows fill often.
    repeat (4) begin
      k_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 24);
      set_keep(CFG_W'(k_pick));
      queue_items(100, ((k_pick > MAX_KEEP) ? MAX_KEEP : k_pick) * 2 + 8);
    end

    set_keep(KEEP_COUNT_RESET);
    queue_items(130, 40);

    wait_idle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      failures++;
    end
    $display("Filtered %0d entries in %0d opened sketches (%0d kept) across %0d k values.",
             entries_taken, sketches_opened, kept_total, settings_seen);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches found", failures);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
